// File: rtl/msvf_pkg.sv
`timescale 1ns / 1ps

package msvf_pkg;

    localparam int CH_W      = 3;
    localparam int SMP_W     = 24;
    localparam int STATE_W   = 32;
    localparam int FREQ_W    = 17;
    localparam int DAMP_W    = 18;
    localparam int DRIVE_W   = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 18;

    localparam int MUL_A_W   = 37;
    localparam int MUL_B_W   = 33;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int SUM_W     = 40;
    localparam int SQ_W      = 37;
    localparam int TERM_W    = 34;
    localparam int ACC_W     = STATE_W + 1;

    localparam int RND_COEF  = 16;
    localparam int RND_SQ    = 27;
    localparam int RND_OUT   = 5;

    localparam logic [CFG_IDX_W-1:0] REG_FREQ  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DAMP  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_RESP  = CFG_IDX_W'(3);

    localparam logic [DAMP_W-1:0] DAMP_RESET = DAMP_W'(131072);

    typedef enum logic [1:0] {
        RESP_LOW   = 2'd0,
        RESP_HIGH  = 2'd1,
        RESP_BAND  = 2'd2,
        RESP_NOTCH = 2'd3
    } t_resp;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_RUN  = 3'b100
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DAMP_BAND,
        MUL_FREQ_BAND,
        MUL_BAND_BAND,
        MUL_FREQ_HIGH,
        MUL_DRIVE_SQ
    } t_mul;

    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_NOTCH,
        ALU_LOW,
        ALU_HIGH_SQ,
        ALU_TERM,
        ALU_BAND,
        ALU_ACC,
        ALU_DONE
    } t_alu;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_LOOP,
        SEQ_END
    } t_seq;

    localparam int STEP_W     = 4;
    localparam int UCODE_LEN  = 9;

    typedef struct packed {
        t_mul              mul;
        t_alu              alu;
        t_seq              seq;
        logic [STEP_W-1:0] target;
    } t_uop;

    localparam t_uop UCODE [UCODE_LEN] = '{
        '{mul: MUL_DAMP_BAND, alu: ALU_NOP,     seq: SEQ_NEXT, target: STEP_W'(0)},
        '{mul: MUL_FREQ_BAND, alu: ALU_NOTCH,   seq: SEQ_NEXT, target: STEP_W'(0)},
        '{mul: MUL_BAND_BAND, alu: ALU_LOW,     seq: SEQ_NEXT, target: STEP_W'(0)},
        '{mul: MUL_NONE,      alu: ALU_HIGH_SQ, seq: SEQ_NEXT, target: STEP_W'(0)},
        '{mul: MUL_FREQ_HIGH, alu: ALU_NOP,     seq: SEQ_NEXT, target: STEP_W'(0)},
        '{mul: MUL_DRIVE_SQ,  alu: ALU_TERM,    seq: SEQ_NEXT, target: STEP_W'(0)},
        '{mul: MUL_NONE,      alu: ALU_BAND,    seq: SEQ_NEXT, target: STEP_W'(0)},
        '{mul: MUL_DAMP_BAND, alu: ALU_ACC,     seq: SEQ_LOOP, target: STEP_W'(1)},
        '{mul: MUL_NONE,      alu: ALU_DONE,    seq: SEQ_END,  target: STEP_W'(0)}
    };

    function automatic logic signed [PROD_W-1:0] round_shift(
        input logic signed [PROD_W-1:0] v,
        input int                       k
    );
        logic signed [PROD_W-1:0] half;
        half = PROD_W'(1) <<< (k - 1);
        return (v + half) >>> k;
    endfunction

    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(64'sd2147483647);
        lo = -SUM_W'(64'sd2147483648);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[STATE_W-1:0];
    endfunction

    function automatic logic signed [SMP_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(64'sd8388607);
        lo = -SUM_W'(64'sd8388608);
        if (v > hi) begin
            return 24'sh7F_FFFF;
        end else if (v < lo) begin
            return 24'sh80_0000;
        end
        return v[SMP_W-1:0];
    endfunction

endpackage

// File: rtl/multichannel_state_variable_filter_core.sv
`timescale 1ns / 1ps
// Multichannel double-sampled state variable filter.
// Slave stream: tuser carries the channel, tdata the signed Q1.23 sample.
// Master stream: tuser echoes the channel, tdata the filtered Q1.23 sample.
// Configuration channel: index 0 frequency, 1 damping, 2 drive, 3 response
// select; writes are always taken and apply to the next sample. Write only
// while no sample is in flight.
// Each sample fetches its channel's lowpass/bandpass state from a RAM, runs
// a 16-step program over one shared multiplier (two filter passes), writes
// the state back and loads the result register. A new sample is taken only
// once the previous one has finished, as the single multiplier steps
// through the program.
// A channel at or beyond CHANNELS leaves state alone and returns zero.
// Reset clears all channel state to zero (per-channel valid bits), sets the
// damping to 2.0 and the other registers to zero.
// When the receiver stalls, the finished result holds in the output
// register; the program waits on its final step until the register frees.

module multichannel_state_variable_filter_core
    import msvf_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // [23:0] sample_in
    input  logic [CH_W-1:0]      s_axis_tuser,   // [2:0] channel
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // [23:0] sample_out
    output logic [CH_W-1:0]      m_axis_tuser,   // [2:0] channel_out
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RAM_W = 2 * STATE_W;

    t_state                     r_state, n_state;
    logic [STEP_W-1:0]          r_step, n_step;
    logic                       r_pass, n_pass;
    logic                       r_out_valid, n_out_valid;
    logic [CHANNELS-1:0]        r_valid;

    logic [FREQ_W-1:0]          r_freq;
    logic [DAMP_W-1:0]          r_damp;
    logic [DRIVE_W-1:0]         r_drive;
    t_resp                      r_resp;

    logic [CH_W-1:0]            r_ch, n_ch;
    logic [AW-1:0]              r_addr, n_addr;
    logic                       r_skip, n_skip;
    logic signed [STATE_W-1:0]  r_x, n_x;
    logic signed [STATE_W-1:0]  r_low, n_low;
    logic signed [STATE_W-1:0]  r_band, n_band;
    logic signed [STATE_W-1:0]  r_notch, n_notch;
    logic signed [STATE_W-1:0]  r_high, n_high;
    logic signed [SQ_W-1:0]     r_sq, n_sq;
    logic signed [TERM_W-1:0]   r_t, n_t;
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic signed [PROD_W-1:0]   r_prod;
    logic [CH_W-1:0]            r_out_ch, n_out_ch;
    logic signed [SMP_W-1:0]    r_out_smp, n_out_smp;

    t_uop                       w_uop;
    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic signed [MUL_B_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   w_r16;
    logic signed [PROD_W-1:0]   w_r27;
    logic signed [STATE_W-1:0]  w_sel;
    logic signed [SUM_W-1:0]    w_out_rnd;
    logic                       w_out_free;
    logic                       w_in_xfer;
    logic                       w_in_range;
    logic [AW+CH_W-1:0]         w_ch_ext;
    logic [AW-1:0]              w_rd_addr;
    logic                       w_wr_en;
    logic [RAM_W-1:0]           w_rd_data;
    logic                       w_cfg_xfer;

    assign w_uop      = (r_step < STEP_W'(UCODE_LEN)) ? UCODE[r_step] : UCODE[UCODE_LEN-1];
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_ch_ext   = (AW + CH_W)'(s_axis_tuser);
    assign w_rd_addr  = w_ch_ext[AW-1:0];
    assign w_in_range = (32'(s_axis_tuser) < 32'(CHANNELS));
    assign o_cfg_ready = 1'b1;
    assign w_cfg_xfer = i_cfg_valid && o_cfg_ready;

    msvf_ram #(
        .WIDTH (RAM_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data ({r_low, r_band}),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (w_uop.mul)
            MUL_DAMP_BAND: begin
                w_mul_a = MUL_A_W'(r_band);
                w_mul_b = $signed(MUL_B_W'(r_damp));
            end
            MUL_FREQ_BAND: begin
                w_mul_a = MUL_A_W'(r_band);
                w_mul_b = $signed(MUL_B_W'(r_freq));
            end
            MUL_BAND_BAND: begin
                w_mul_a = MUL_A_W'(r_band);
                w_mul_b = MUL_B_W'(r_band);
            end
            MUL_FREQ_HIGH: begin
                w_mul_a = MUL_A_W'(r_high);
                w_mul_b = $signed(MUL_B_W'(r_freq));
            end
            MUL_DRIVE_SQ: begin
                w_mul_a = r_sq;
                w_mul_b = $signed(MUL_B_W'(r_drive));
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_r16  = round_shift(r_prod, RND_COEF);
    assign w_r27  = round_shift(r_prod, RND_SQ);
    assign w_out_rnd = (SUM_W'(r_acc) + SUM_W'(1 << (RND_OUT - 1))) >>> RND_OUT;

    always_comb begin
        case (r_resp)
            RESP_LOW:  w_sel = r_low;
            RESP_HIGH: w_sel = r_high;
            RESP_BAND: w_sel = r_band;
            default:   w_sel = r_notch;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_pass      = r_pass;
        n_ch        = r_ch;
        n_addr      = r_addr;
        n_skip      = r_skip;
        n_x         = r_x;
        n_low       = r_low;
        n_band      = r_band;
        n_notch     = r_notch;
        n_high      = r_high;
        n_sq        = r_sq;
        n_t         = r_t;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_ch    = r_out_ch;
        n_out_smp   = r_out_smp;
        w_wr_en     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_ch    = s_axis_tuser;
                    n_addr  = w_rd_addr;
                    n_skip  = !w_in_range;
                    n_x     = STATE_W'($signed(s_axis_tdata)) <<< 4;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (r_valid[r_addr]) begin
                    n_low  = $signed(w_rd_data[RAM_W-1:STATE_W]);
                    n_band = $signed(w_rd_data[STATE_W-1:0]);
                end else begin
                    n_low  = '0;
                    n_band = '0;
                end
                n_acc   = '0;
                n_step  = '0;
                n_pass  = 1'b0;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                case (w_uop.alu)
                    ALU_NOTCH: n_notch = sat32(SUM_W'(r_x) - $signed(w_r16[SUM_W-1:0]));
                    ALU_LOW:   n_low   = sat32(SUM_W'(r_low) + $signed(w_r16[SUM_W-1:0]));
                    ALU_HIGH_SQ: begin
                        n_high = sat32(SUM_W'(r_notch) - SUM_W'(r_low));
                        n_sq   = $signed(w_r27[SQ_W-1:0]);
                    end
                    ALU_TERM:  n_t     = $signed(w_r16[TERM_W-1:0]);
                    ALU_BAND:  n_band  = sat32(SUM_W'(r_t) + SUM_W'(r_band)
                                               - $signed(w_r16[SUM_W-1:0]));
                    ALU_ACC:   n_acc   = r_acc + ACC_W'(w_sel);
                    default: ;
                endcase

                case (w_uop.seq)
                    SEQ_LOOP: begin
                        if (!r_pass) begin
                            n_pass = 1'b1;
                            n_step = w_uop.target;
                        end else begin
                            n_step = r_step + STEP_W'(1);
                        end
                    end
                    SEQ_END: begin
                        if (w_out_free) begin
                            w_wr_en     = !r_skip;
                            n_out_valid = 1'b1;
                            n_out_ch    = r_ch;
                            n_out_smp   = r_skip ? '0 : sat24(w_out_rnd);
                            n_state     = ST_IDLE;
                        end
                    end
                    default: n_step = r_step + STEP_W'(1);
                endcase
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_freq      <= '0;
            r_damp      <= DAMP_RESET;
            r_drive     <= '0;
            r_resp      <= RESP_LOW;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
            if (w_wr_en) begin
                r_valid[r_addr] <= 1'b1;
            end
            if (w_cfg_xfer) begin
                case (i_cfg_index)
                    REG_FREQ:  r_freq  <= i_cfg_data[FREQ_W-1:0];
                    REG_DAMP:  r_damp  <= i_cfg_data[DAMP_W-1:0];
                    REG_DRIVE: r_drive <= i_cfg_data[DRIVE_W-1:0];
                    REG_RESP:  r_resp  <= t_resp'(i_cfg_data[1:0]);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch      <= n_ch;
        r_addr    <= n_addr;
        r_skip    <= n_skip;
        r_x       <= n_x;
        r_low     <= n_low;
        r_band    <= n_band;
        r_notch   <= n_notch;
        r_high    <= n_high;
        r_sq      <= n_sq;
        r_t       <= n_t;
        r_acc     <= n_acc;
        r_prod    <= w_prod;
        r_out_ch  <= n_out_ch;
        r_out_smp <= n_out_smp;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_smp;
    assign m_axis_tuser  = r_out_ch;

endmodule

// File: rtl/msvf_ram.sv
`timescale 1ns / 1ps

module msvf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: tb/sv/tb_multichannel_state_variable_filter_core.sv
`timescale 1ns / 1ps

module tb_multichannel_state_variable_filter_core;
    import msvf_pkg::*;

    localparam int N_CH        = 8;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 103;
    localparam int HOLD_PHASE  = 4;
    localparam int LONG_HOLD   = 200;
    localparam int SETTLE      = 24;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [SMP_W-1:0] SMP_MAX = 24'h7F_FFFF;
    localparam logic [SMP_W-1:0] SMP_MIN = 24'h80_0000;
    localparam logic [SMP_W-1:0] SMP_ONE = 24'h00_0001;
    localparam logic [SMP_W-1:0] SMP_NEG = 24'hFF_FFFF;

    localparam logic [FREQ_W-1:0]  FREQ_TOP   = FREQ_W'(92682);
    localparam logic [FREQ_W-1:0]  FREQ_FULL  = {FREQ_W{1'b1}};
    localparam logic [DAMP_W-1:0]  DAMP_FULL  = {DAMP_W{1'b1}};
    localparam logic [DRIVE_W-1:0] DRIVE_FULL = {DRIVE_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_FREE = REG_RESP + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_FREE  = {CFG_IDX_W{1'b1}};

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [SMP_W-1:0] smp;
    } filtered_t;

    class filter_model;
        logic signed [STATE_W-1:0] low_st  [N_CH];
        logic signed [STATE_W-1:0] band_st [N_CH];
        logic [FREQ_W-1:0]         freq;
        logic [DAMP_W-1:0]         damp;
        logic [DRIVE_W-1:0]        drive;
        t_resp                     resp;
        filtered_t                 awaited [$];
        int                        errors;

        function new();
            foreach (low_st[i]) begin
                low_st[i]  = '0;
                band_st[i] = '0;
            end
            freq   = '0;
            damp   = DAMP_RESET;
            drive  = '0;
            resp   = RESP_LOW;
            errors = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                REG_FREQ:  freq  = val[FREQ_W-1:0];
                REG_DAMP:  damp  = val[DAMP_W-1:0];
                REG_DRIVE: drive = val[DRIVE_W-1:0];
                REG_RESP:  resp  = t_resp'(val[1:0]);
                default: ;
            endcase
        endfunction

        function longint rshift_round(longint v, int k);
            return (v + (longint'(1) <<< (k - 1))) >>> k;
        endfunction

        function longint clamp_state(longint v);
            if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
            if (v < longint'(32'sh8000_0000)) return longint'(32'sh8000_0000);
            return v;
        endfunction

        function longint clamp_sample(longint v);
            if (v > longint'(24'sh7F_FFFF)) return longint'(24'sh7F_FFFF);
            if (v < longint'(24'sh80_0000)) return longint'(24'sh80_0000);
            return v;
        endfunction

        function longint run_pass(longint x, inout longint lo, inout longint bp);
            longint notch;
            longint hp;
            longint sq;
            notch = clamp_state(x - rshift_round(longint'(damp) * bp, RND_COEF));
            lo    = clamp_state(lo + rshift_round(longint'(freq) * bp, RND_COEF));
            hp    = clamp_state(notch - lo);
            sq    = rshift_round(bp * bp, RND_SQ);
            bp    = clamp_state(rshift_round(longint'(freq) * hp, RND_COEF) + bp
                                - rshift_round(longint'(drive) * sq, RND_COEF));
            case (resp)
                RESP_LOW:  return lo;
                RESP_HIGH: return hp;
                RESP_BAND: return bp;
                default:   return notch;
            endcase
        endfunction

        function void take_sample(logic [CH_W-1:0] ch, logic [SMP_W-1:0] smp);
            longint x;
            longint lo;
            longint bp;
            longint first;
            longint second;
            filtered_t want;
            want.ch = ch;
            if (int'(ch) >= N_CH) begin
                want.smp = '0;
            end else begin
                x      = longint'($signed(smp)) * 16;
                lo     = longint'(low_st[ch]);
                bp     = longint'(band_st[ch]);
                first  = run_pass(x, lo, bp);
                second = run_pass(x, lo, bp);
                low_st[ch]  = STATE_W'(lo);
                band_st[ch] = STATE_W'(bp);
                want.smp = SMP_W'(clamp_sample(rshift_round(first + second, RND_OUT)));
            end
            awaited.push_back(want);
        endfunction

        task flag(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task match_output(logic [CH_W-1:0] ch, logic [SMP_W-1:0] smp);
            filtered_t want;
            if (awaited.size() == 0) begin
                flag($sformatf("unexpected output ch %0d sample %h", ch, smp));
            end else begin
                want = awaited.pop_front();
                if (ch !== want.ch)
                    flag($sformatf("channel got %0d want %0d", ch, want.ch));
                if (smp !== want.smp)
                    flag($sformatf("ch %0d sample got %h want %h", want.ch, smp, want.smp));
            end
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata;   // [23:0] sample_in
    logic [CH_W-1:0]      s_axis_tuser;   // [2:0] channel
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [23:0]          m_axis_tdata;   // [23:0] sample_out
    logic [CH_W-1:0]      m_axis_tuser;   // [2:0] channel_out
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    filter_model fm = new();
    bit          allow_idle;
    bit          long_hold_req;
    int          stall_left;
    int          cycle_count;

    multichannel_state_variable_filter_core #(
        .CHANNELS(N_CH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // output side: check each transfer, then decide the next ready
    initial begin
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                fm.match_output(m_axis_tuser, m_axis_tdata);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else if (allow_idle && $urandom_range(0, 4) == 0) begin
                stall_left    = $urandom_range(1, 5) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= ch;
        s_axis_tdata  <= smp;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        fm.take_sample(ch, smp);
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        fm.set_reg(idx, val);
    endtask

    task automatic write_settings(
        input logic [FREQ_W-1:0]  freq,
        input logic [DAMP_W-1:0]  damp,
        input logic [DRIVE_W-1:0] drive,
        input t_resp              resp,
        input bit                 stray
    );
        write_reg(REG_FREQ, CFG_DAT_W'(freq));
        write_reg(REG_DAMP, CFG_DAT_W'(damp));
        write_reg(REG_DRIVE, CFG_DAT_W'(drive));
        write_reg(REG_RESP, CFG_DAT_W'(resp));
        if (stray)
            write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_FREE, REG_LAST_FREE)),
                      CFG_DAT_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // drop valid and wait until every result is out and the core is idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (fm.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2, 3:    return SMP_W'($urandom_range(0, 16383)) - SMP_W'(8192);
            default: return SMP_W'($urandom);
        endcase
    endfunction

    function automatic logic [FREQ_W-1:0] rand_freq();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return FREQ_TOP;
            2:       return FREQ_FULL;
            3, 4:    return FREQ_W'($urandom_range(0, 20000));
            default: return FREQ_W'($urandom);
        endcase
    endfunction

    function automatic logic [DAMP_W-1:0] rand_damp();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return DAMP_RESET;
            2:       return DAMP_FULL;
            default: return DAMP_W'($urandom);
        endcase
    endfunction

    function automatic logic [DRIVE_W-1:0] rand_drive();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return DRIVE_FULL;
            default: return DRIVE_W'($urandom);
        endcase
    endfunction

    initial begin
        int               n;
        int               len;
        bit               hold_done;
        logic [CH_W-1:0]  ch;
        logic [SMP_W-1:0] level;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        allow_idle    = 1'b0;
        long_hold_req = 1'b0;
        hold_done     = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset settings: lowpass, zero frequency, damping 2.0
        send_sample(3'd0, SMP_MAX);
        send_sample(3'd7, SMP_MIN);
        send_sample(3'd3, '0);
        send_sample(3'd4, SMP_NEG);
        send_sample(3'd5, SMP_ONE);
        drain();

        write_settings(FREQ_TOP, '0, DRIVE_FULL, RESP_HIGH, 1'b1);
        send_sample(3'd1, SMP_MAX);
        send_sample(3'd1, SMP_MAX);
        send_sample(3'd1, SMP_MAX);
        send_sample(3'd1, SMP_MIN);
        send_sample(3'd6, SMP_MAX);
        send_sample(3'd0, SMP_NEG);
        drain();

        // coefficients beyond their nominal range
        write_settings(FREQ_FULL, DAMP_FULL, '0, RESP_BAND, 1'b0);
        send_sample(3'd2, SMP_MAX);
        send_sample(3'd2, SMP_MAX);
        send_sample(3'd2, SMP_MIN);
        send_sample(3'd2, SMP_MIN);
        send_sample(3'd7, SMP_MAX);
        send_sample(3'd1, '0);
        drain();

        write_settings(FREQ_W'(40000), DAMP_RESET, DRIVE_W'(32768), RESP_NOTCH, 1'b0);
        send_sample(3'd3, SMP_MIN);
        send_sample(3'd3, SMP_MIN);
        send_sample(3'd3, SMP_MIN);
        send_sample(3'd3, SMP_MAX);
        send_sample(3'd0, SMP_MAX);
        send_sample(3'd5, SMP_ONE);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            allow_idle = (phase < PHASES - 2) && (phase % 3 != 2);
            write_settings(rand_freq(), rand_damp(), rand_drive(),
                           t_resp'($urandom_range(0, 3)), bit'($urandom_range(0, 1)));
            n = 0;
            while (n < PHASE_ITEMS) begin
                if (phase == HOLD_PHASE && n >= 20 && !hold_done) begin
                    long_hold_req = 1'b1;
                    hold_done     = 1'b1;
                end
                if ($urandom_range(0, 2) == 0) begin
                    // square wave on one channel to build up its state
                    ch    = CH_W'($urandom);
                    len   = $urandom_range(4, 16);
                    level = rand_sample();
                    for (int j = 0; j < len; j++) begin
                        send_sample(ch, (j % 8 < 4) ? level : -level);
                        n++;
                    end
                end else begin
                    send_sample(CH_W'($urandom), rand_sample());
                    n++;
                end
            end
            drain();
        end

        if (fm.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/msvf_pkg.sv
rtl/msvf_ram.sv
rtl/multichannel_state_variable_filter_core.sv
tb/sv/tb_multichannel_state_variable_filter_core.sv
